// ----- src/quadratic_root_solver_top_assert.svh -----
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define QRS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that must hold on every clock edge outside reset
`define QRS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ----- src/qrs_pkg.sv -----
// types and constants shared by the quadratic root solver
package qrs_pkg;
	localparam int CoefW = 16;
	localparam int FracW = 16;
	localparam int RootW = 40;
	localparam int DiscW = 2 * CoefW + 2;
	localparam int RadW  = DiscW + 2 * FracW;
	localparam int SqW   = RadW / 2;
	localparam int NbW   = CoefW + FracW + 1;
	localparam int NumW  = SqW + 2;
	localparam int DenW  = CoefW + 1;

	localparam logic [1:0] CntNone = 2'd0;
	localparam logic [1:0] CntOne  = 2'd1;
	localparam logic [1:0] CntTwo  = 2'd2;

	typedef struct packed {
		logic signed [CoefW-1:0] coef_sq;
		logic signed [CoefW-1:0] coef_lin;
		logic signed [CoefW-1:0] coef_const;
	} qrs_in_t;

	typedef struct packed {
		logic [1:0]              root_count;
		logic signed [RootW-1:0] root_plus;
		logic signed [RootW-1:0] root_minus;
		logic                    lead_zero;
	} qrs_out_t;

	// side data that rides along with the square root
	typedef struct packed {
		logic [1:0]            cnt;
		logic                  lead_zero;
		logic signed [NbW-1:0] nb;
		logic signed [DenW-1:0] den;
	} qrs_meta_t;

	// side data that rides along with the divider
	typedef struct packed {
		logic [1:0] cnt;
		logic       lead_zero;
		logic       neg_p;
		logic       neg_m;
	} qrs_tag_t;
endpackage

// ----- src/quadratic_root_solver_top.sv -----
// quadratic root solver: real roots of a*x^2 + b*x + c in signed Q.16
//
// input channel: coefs carries a, b and c; a beat is taken at a rising edge
// with start high and busy low. busy is held low: a new coefficient set may
// enter on every cycle, back to back, one per clock sustained.
// output channel: result is valid for exactly one cycle while done is high.
// the receiver cannot stall, so no back-pressure exists anywhere inside.
// a beat passes, in order, the products and discriminant registers, the
// square root (one root bit per stage), the numerator register, the divider
// (one quotient bit per stage) and the output register; the depth of the
// root and divider chains sets most of the latency.
// results leave in the order the beats entered.
// reset clears only the valid bits of every stage; an in-flight set is
// dropped and done stays low until a new beat has passed all stages.
// a zero leading coefficient sets lead_zero and forces both roots to zero;
// a negative discriminant gives a root count of zero and zero roots.
module quadratic_root_solver_top import qrs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  qrs_in_t  coefs,
	output logic     done,
	output qrs_out_t result
);
	logic            accept;
	logic            disc_vld;
	logic [RadW-1:0] disc_rad;
	qrs_meta_t       disc_meta;
	logic            sq_vld;
	logic [SqW-1:0]  sq_root;
	qrs_meta_t       sq_meta;

	// numerator stage
	logic            vld_s3;
	logic [NumW-1:0] nump_s3;
	logic [NumW-1:0] numm_s3;
	logic [DenW-1:0] den_s3;
	qrs_tag_t        tag_s3;

	logic signed [NumW-1:0] sum_p;
	logic signed [NumW-1:0] sum_m;
	logic                   den_neg;

	logic            div_vld;
	logic [NumW-1:0] quo_p;
	logic [NumW-1:0] quo_m;
	qrs_tag_t        div_tag;

	logic signed [NumW-1:0] root_p;
	logic signed [NumW-1:0] root_m;
	logic                   zero_roots;

	// never stalls: one beat per cycle is always taken
	assign busy   = 1'b0;
	assign accept = start && !busy;

	qrs_disc u_disc (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.in_beat (coefs),
		.out_vld (disc_vld),
		.rad     (disc_rad),
		.meta    (disc_meta)
	);

	qrs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (disc_vld),
		.rad      (disc_rad),
		.in_meta  (disc_meta),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.out_meta (sq_meta)
	);

	// -b*2^frac plus or minus the root, then split into sign and magnitude
	always_comb begin
		sum_p   = NumW'(sq_meta.nb) + $signed(NumW'(sq_root));
		sum_m   = NumW'(sq_meta.nb) - $signed(NumW'(sq_root));
		den_neg = sq_meta.den[DenW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		nump_s3           <= sum_p[NumW-1] ? NumW'(-sum_p) : sum_p;
		numm_s3           <= sum_m[NumW-1] ? NumW'(-sum_m) : sum_m;
		den_s3            <= den_neg ? DenW'(-sq_meta.den) : sq_meta.den;
		tag_s3.cnt        <= sq_meta.cnt;
		tag_s3.lead_zero  <= sq_meta.lead_zero;
		tag_s3.neg_p      <= sum_p[NumW-1] ^ den_neg;
		tag_s3.neg_m      <= sum_m[NumW-1] ^ den_neg;
	end

	qrs_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s3),
		.num_p   (nump_s3),
		.num_m   (numm_s3),
		.den     (den_s3),
		.in_tag  (tag_s3),
		.out_vld (div_vld),
		.quo_p   (quo_p),
		.quo_m   (quo_m),
		.out_tag (div_tag)
	);

	// restore the quotient sign; truncation toward zero falls out of the magnitudes
	always_comb begin
		root_p     = div_tag.neg_p ? -$signed(quo_p) : $signed(quo_p);
		root_m     = div_tag.neg_m ? -$signed(quo_m) : $signed(quo_m);
		zero_roots = div_tag.lead_zero || (div_tag.cnt == CntNone);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		result.root_count <= div_tag.cnt;
		result.lead_zero  <= div_tag.lead_zero;
		result.root_plus  <= zero_roots ? '0 : RootW'(root_p);
		result.root_minus <= zero_roots ? '0 : RootW'(root_m);
	end

`include "quadratic_root_solver_top_assert.svh"

	`QRS_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised on a non-stalling pipe")
	`QRS_ASSERT_IMPLY(a_lead_zero_roots, done && result.lead_zero,
		result.root_plus == 0 && result.root_minus == 0, "roots not zero with a == 0")
	`QRS_ASSERT_IMPLY(a_no_root_zero, done && result.root_count == CntNone,
		result.root_plus == 0 && result.root_minus == 0, "roots not zero without real roots")
	`QRS_ASSERT_IMPLY(a_single_root, done && result.root_count == CntOne,
		result.root_plus == result.root_minus, "double root differs between fields")
endmodule

// ----- src/qrs_disc.sv -----
// products and discriminant, two register stages
module qrs_disc import qrs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  qrs_in_t          in_beat,
	output logic             out_vld,
	output logic [RadW-1:0]  rad,
	output qrs_meta_t        meta
);
	logic                     vld_s1;
	logic signed [2*CoefW-1:0] bsq_s1;
	logic signed [2*CoefW-1:0] ac_s1;
	logic signed [CoefW-1:0]  a_s1;
	logic signed [CoefW-1:0]  b_s1;
	logic signed [DiscW-1:0]  disc;
	logic [1:0]               cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		bsq_s1 <= (2*CoefW)'(in_beat.coef_lin) * (2*CoefW)'(in_beat.coef_lin);
		ac_s1  <= (2*CoefW)'(in_beat.coef_sq) * (2*CoefW)'(in_beat.coef_const);
		a_s1   <= in_beat.coef_sq;
		b_s1   <= in_beat.coef_lin;
	end

	always_comb begin
		disc = DiscW'(bsq_s1) - (DiscW'(ac_s1) <<< 2);
		if (disc > 0) begin
			cnt = CntTwo;
		end else if (disc == 0) begin
			cnt = CntOne;
		end else begin
			cnt = CntNone;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		rad            <= disc[DiscW-1] ? '0 : {disc, {(2*FracW){1'b0}}};
		meta.cnt       <= cnt;
		meta.lead_zero <= (a_s1 == 0);
		meta.nb        <= -(NbW'(b_s1) <<< FracW);
		meta.den       <= DenW'(a_s1) <<< 1;
	end
endmodule

// ----- src/qrs_sqrt.sv -----
// integer square root, one result bit per pipeline stage
module qrs_sqrt import qrs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [RadW-1:0] rad,
	input  qrs_meta_t       in_meta,
	output logic            out_vld,
	output logic [SqW-1:0]  root,
	output qrs_meta_t       out_meta
);
	localparam int RemW = SqW + 3;

	logic            vld_q  [0:SqW];
	logic [RemW-1:0] rem_q  [0:SqW];
	logic [SqW-1:0]  root_q [0:SqW];
	logic [RadW-1:0] rad_q  [0:SqW];
	qrs_meta_t       meta_q [0:SqW];

	logic [RemW-1:0] rem_n  [0:SqW-1];
	logic [SqW-1:0]  root_n [0:SqW-1];

	assign vld_q[0]  = in_vld;
	assign rem_q[0]  = '0;
	assign root_q[0] = '0;
	assign rad_q[0]  = rad;
	assign meta_q[0] = in_meta;

	always_comb begin
		for (int i = 0; i < SqW; i++) begin
			logic [RemW-1:0] shifted;
			logic [RemW-1:0] trial;
			shifted = {rem_q[i][RemW-3:0], rad_q[i][RadW-1 -: 2]};
			trial   = {1'b0, root_q[i], 2'b01};
			if (shifted >= trial) begin
				rem_n[i]  = shifted - trial;
				root_n[i] = {root_q[i][SqW-2:0], 1'b1};
			end else begin
				rem_n[i]  = shifted;
				root_n[i] = {root_q[i][SqW-2:0], 1'b0};
			end
		end
	end

	for (genvar g = 0; g < SqW; g++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g+1] <= 1'b0;
			end else begin
				vld_q[g+1] <= vld_q[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_q[g+1]  <= rem_n[g];
			root_q[g+1] <= root_n[g];
			rad_q[g+1]  <= {rad_q[g][RadW-3:0], 2'b00};
			meta_q[g+1] <= meta_q[g];
		end
	end

	assign out_vld  = vld_q[SqW];
	assign root     = root_q[SqW];
	assign out_meta = meta_q[SqW];
endmodule

// ----- src/qrs_div.sv -----
// two-lane restoring divider on magnitudes, one quotient bit per stage
module qrs_div import qrs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [NumW-1:0] num_p,
	input  logic [NumW-1:0] num_m,
	input  logic [DenW-1:0] den,
	input  qrs_tag_t        in_tag,
	output logic            out_vld,
	output logic [NumW-1:0] quo_p,
	output logic [NumW-1:0] quo_m,
	output qrs_tag_t        out_tag
);
	logic            vld_q  [0:NumW];
	logic [DenW-1:0] remp_q [0:NumW];
	logic [DenW-1:0] remm_q [0:NumW];
	logic [NumW-1:0] nump_q [0:NumW];
	logic [NumW-1:0] numm_q [0:NumW];
	logic [DenW-1:0] den_q  [0:NumW];
	qrs_tag_t        tag_q  [0:NumW];

	logic [DenW-1:0] remp_n [0:NumW-1];
	logic [DenW-1:0] remm_n [0:NumW-1];
	logic [NumW-1:0] nump_n [0:NumW-1];
	logic [NumW-1:0] numm_n [0:NumW-1];

	assign vld_q[0]  = in_vld;
	assign remp_q[0] = '0;
	assign remm_q[0] = '0;
	assign nump_q[0] = num_p;
	assign numm_q[0] = num_m;
	assign den_q[0]  = den;
	assign tag_q[0]  = in_tag;

	// numerator register shifts left, quotient bits enter at the bottom
	always_comb begin
		for (int i = 0; i < NumW; i++) begin
			logic [DenW:0] rp;
			logic [DenW:0] rm;
			rp = {remp_q[i], nump_q[i][NumW-1]};
			rm = {remm_q[i], numm_q[i][NumW-1]};
			if (rp >= {1'b0, den_q[i]}) begin
				remp_n[i] = DenW'(rp - {1'b0, den_q[i]});
				nump_n[i] = {nump_q[i][NumW-2:0], 1'b1};
			end else begin
				remp_n[i] = rp[DenW-1:0];
				nump_n[i] = {nump_q[i][NumW-2:0], 1'b0};
			end
			if (rm >= {1'b0, den_q[i]}) begin
				remm_n[i] = DenW'(rm - {1'b0, den_q[i]});
				numm_n[i] = {numm_q[i][NumW-2:0], 1'b1};
			end else begin
				remm_n[i] = rm[DenW-1:0];
				numm_n[i] = {numm_q[i][NumW-2:0], 1'b0};
			end
		end
	end

	for (genvar g = 0; g < NumW; g++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g+1] <= 1'b0;
			end else begin
				vld_q[g+1] <= vld_q[g];
			end
		end

		always_ff @(posedge clk) begin
			remp_q[g+1] <= remp_n[g];
			remm_q[g+1] <= remm_n[g];
			nump_q[g+1] <= nump_n[g];
			numm_q[g+1] <= numm_n[g];
			den_q[g+1]  <= den_q[g];
			tag_q[g+1]  <= tag_q[g];
		end
	end

	assign out_vld = vld_q[NumW];
	assign quo_p   = nump_q[NumW];
	assign quo_m   = numm_q[NumW];
	assign out_tag = tag_q[NumW];
endmodule
